[design/pms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, constants and helpers for the 2D point mass step block.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MASS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION  = 2'd2;

  localparam logic [30:0] MASS_RESET      = 31'd65536;
  localparam logic [30:0] MAX_SPEED_RESET = 31'd6553600;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIV_INIT_ACC,
    OP_DIV_STEP,
    OP_ACC,
    OP_DV,
    OP_MOVE,
    OP_SQX,
    OP_SQY,
    OP_SQL,
    OP_SUM,
    OP_CMP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_SCX,
    OP_SCY,
    OP_DIV_INIT_SC,
    OP_SDONE,
    OP_FRIC,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DINIT,
    S_DSTEP,
    S_ACC,
    S_DV,
    S_MOVE,
    S_SQX,
    S_SQY,
    S_SQL,
    S_SUM,
    S_CMP,
    S_RINIT,
    S_RSTEP,
    S_SCX,
    S_SCY,
    S_SINIT,
    S_SSTEP,
    S_SDONE,
    S_FRIC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic clamp;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] apply_sign(input logic [31:0] m, input logic neg);
    return neg ? (~m + 32'd1) : m;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'h7fff_ffff;
    if (v < -49'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

[design/pms_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer: steps the datapath through divide, multiply, root, rescale and friction.
// ----------------------------------------------------------------------------
module pms_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_cmd,
  output logic              in_ready,
  input  pms_pkg::sts_t     sts,
  output pms_pkg::op_t      op
);
  import pms_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_CAPTURE;
          state_nxt = in_cmd ? S_EMIT : S_DINIT;
        end
      end
      S_DINIT: begin
        op        = OP_DIV_INIT_ACC;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        op      = OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_ACC;
      end
      S_ACC: begin
        op        = OP_ACC;
        state_nxt = S_DV;
      end
      S_DV: begin
        op        = OP_DV;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        op        = OP_MOVE;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        op        = OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        op        = OP_SQY;
        state_nxt = S_SQL;
      end
      S_SQL: begin
        op        = OP_SQL;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        op        = OP_SUM;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        op        = OP_CMP;
        state_nxt = S_RINIT;
      end
      S_RINIT: begin
        if (sts.clamp) begin
          op        = OP_SQRT_INIT;
          cnt_nxt   = CNT_W'(SQRT_STEPS - 1);
          state_nxt = S_RSTEP;
        end else begin
          state_nxt = S_FRIC;
        end
      end
      S_RSTEP: begin
        op      = OP_SQRT_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_SCX;
      end
      S_SCX: begin
        op        = OP_SCX;
        state_nxt = S_SCY;
      end
      S_SCY: begin
        op        = OP_SCY;
        state_nxt = S_SINIT;
      end
      S_SINIT: begin
        op        = OP_DIV_INIT_SC;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_SSTEP;
      end
      S_SSTEP: begin
        op      = OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_SDONE;
      end
      S_SDONE: begin
        op        = OP_SDONE;
        state_nxt = S_FRIC;
      end
      S_FRIC: begin
        op        = OP_FRIC;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && sts.out_busy) |=> (state_r == S_EMIT))
    else $error("result dropped while output busy");
  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTEP && cnt_r != '0) |=> (state_r == S_DSTEP))
    else $error("divide loop left early");
`endif

endmodule
`default_nettype wire

[design/pms_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pms_dp
// Datapath: two divider lanes, shared multiplier, root unit, output register.
// ----------------------------------------------------------------------------
module pms_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  pms_pkg::op_t                            op,
  output pms_pkg::sts_t                           sts,
  input  wire logic [31:0]                        in_force_x,
  input  wire logic [31:0]                        in_force_y,
  input  wire logic [15:0]                        in_step_time,
  input  wire logic [31:0]                        in_load_vx,
  input  wire logic [31:0]                        in_load_vy,
  input  wire logic                               cfg_valid,
  input  wire logic [pms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [31:0]                        cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [31:0]                             out_move_x,
  output logic [31:0]                             out_move_y,
  output logic [31:0]                             out_speed_x,
  output logic [31:0]                             out_speed_y,
  output logic                                    out_clamped
);
  import pms_pkg::*;

  logic [30:0] mass_r, max_speed_r;
  logic [15:0] friction_r;
  logic [31:0] v_r [2];
  logic        out_valid_r;

  logic [31:0] f_r   [2];
  logic [31:0] n_r   [2];
  logic [31:0] m_r   [2];
  logic [31:0] a_r   [2];
  logic [31:0] dvm_r [2];
  logic        dvn_r [2];
  logic [63:0] dd_r  [2];
  logic [31:0] rem_r [2];
  logic [63:0] quo_r [2];
  logic [31:0] dvs_r;
  logic [15:0] dt_r;
  logic [63:0] p1_r, p2_r, p3_r, sq_r, sx_r;
  logic [31:0] root_r;
  logic [34:0] srem_r;
  logic        clamp_r;
  logic [31:0] omx_r, omy_r, osx_r, osy_r;
  logic        ocl_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [30:0] mass_eff;
  logic [34:0] sr_sh, sr_trial;
  logic        sr_ge;

  logic [32:0]        d_sh   [2];
  logic               d_ge   [2];
  logic [32:0]        d_rem  [2];
  logic [31:0]        acc_v  [2];
  logic [47:0]        dv_p   [2];
  logic [31:0]        mv_v   [2];
  logic [31:0]        nv_v   [2];
  logic [31:0]        fr_v   [2];
  logic [31:0]        sc_v   [2];
  logic [63:0]        ac_dd  [2];

  assign sts.clamp    = clamp_r;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign mass_eff     = (mass_r == '0) ? 31'd1 : mass_r;

  always_comb begin
    mul_a = mag32(n_r[0]);
    mul_b = mag32(n_r[0]);
    unique case (op)
      OP_SQY: begin
        mul_a = mag32(n_r[1]);
        mul_b = mag32(n_r[1]);
      end
      OP_SQL: begin
        mul_a = {1'b0, max_speed_r};
        mul_b = {1'b0, max_speed_r};
      end
      OP_SCX: mul_b = {1'b0, max_speed_r};
      OP_SCY: begin
        mul_a = mag32(n_r[1]);
        mul_b = {1'b0, max_speed_r};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign sr_sh    = {srem_r[32:0], sx_r[63:62]};
  assign sr_trial = {1'b0, root_r, 2'b01};
  assign sr_ge    = sr_sh >= sr_trial;

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic signed [48:0] aq_s, mv_s, sum_s, nv_s, v_s, h_s;
    logic        [48:0] mv_m;
    logic        [48:0] mv_p;
    logic        [48:0] fr_p;

    assign d_sh[i]  = {rem_r[i], dd_r[i][63]};
    assign d_ge[i]  = d_sh[i] >= {1'b0, dvs_r};
    assign d_rem[i] = d_ge[i] ? (d_sh[i] - {1'b0, dvs_r}) : d_sh[i];
    assign ac_dd[i] = {16'b0, mag32(f_r[i]), 16'b0};

    assign aq_s     = f_r[i][31] ? -$signed({1'b0, quo_r[i][47:0]})
                                 :  $signed({1'b0, quo_r[i][47:0]});
    assign acc_v[i] = sat32(aq_s);
    assign dv_p[i]  = mag32(a_r[i]) * dt_r;

    assign v_s   = $signed({{17{v_r[i][31]}}, v_r[i]});
    assign h_s   = dvn_r[i] ? -$signed({18'b0, dvm_r[i][31:1]})
                            :  $signed({18'b0, dvm_r[i][31:1]});
    assign sum_s = v_s + h_s;
    assign mv_m  = sum_s[48] ? 49'(-sum_s) : 49'(sum_s);
    assign mv_p  = mv_m[32:0] * dt_r;
    assign mv_s  = sum_s[48] ? -$signed({16'b0, mv_p[48:16]})
                             :  $signed({16'b0, mv_p[48:16]});
    assign mv_v[i] = sat32(mv_s);
    assign nv_s  = v_s + (dvn_r[i] ? -$signed({17'b0, dvm_r[i]})
                                   :  $signed({17'b0, dvm_r[i]}));
    assign nv_v[i] = sat32(nv_s);

    assign sc_v[i] = apply_sign(quo_r[i][31:0], n_r[i][31]);
    assign fr_p    = mag32(n_r[i]) * (17'h1_0000 - {1'b0, friction_r});
    assign fr_v[i] = apply_sign(fr_p[47:16], n_r[i][31]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r      <= MASS_RESET;
      max_speed_r <= MAX_SPEED_RESET;
      friction_r  <= '0;
      v_r[0]      <= '0;
      v_r[1]      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MASS:      mass_r      <= cfg_data[30:0];
          REG_MAX_SPEED: max_speed_r <= cfg_data[30:0];
          REG_FRICTION:  friction_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (op == OP_EMIT) begin
        v_r[0]      <= n_r[0];
        v_r[1]      <= n_r[1];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        f_r[0]  <= in_force_x;
        f_r[1]  <= in_force_y;
        dt_r    <= in_step_time;
        n_r[0]  <= in_load_vx;
        n_r[1]  <= in_load_vy;
        m_r[0]  <= '0;
        m_r[1]  <= '0;
        clamp_r <= 1'b0;
      end
      OP_DIV_INIT_ACC: begin
        for (int i = 0; i < 2; i++) begin
          dd_r[i]  <= ac_dd[i];
          rem_r[i] <= '0;
          quo_r[i] <= '0;
        end
        dvs_r <= {1'b0, mass_eff};
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < 2; i++) begin
          dd_r[i]  <= {dd_r[i][62:0], 1'b0};
          rem_r[i] <= d_rem[i][31:0];
          quo_r[i] <= {quo_r[i][62:0], d_ge[i]};
        end
      end
      OP_ACC: begin
        a_r[0] <= acc_v[0];
        a_r[1] <= acc_v[1];
      end
      OP_DV: begin
        for (int i = 0; i < 2; i++) begin
          dvm_r[i] <= dv_p[i][47:16];
          dvn_r[i] <= a_r[i][31];
        end
      end
      OP_MOVE: begin
        for (int i = 0; i < 2; i++) begin
          m_r[i] <= mv_v[i];
          n_r[i] <= nv_v[i];
        end
      end
      OP_SQX: p1_r <= mul_p;
      OP_SQY: p2_r <= mul_p;
      OP_SQL: p3_r <= mul_p;
      OP_SUM: sq_r <= p1_r + p2_r;
      OP_CMP: clamp_r <= sq_r > p3_r;
      OP_SQRT_INIT: begin
        sx_r   <= sq_r;
        root_r <= '0;
        srem_r <= '0;
      end
      OP_SQRT_STEP: begin
        sx_r   <= {sx_r[61:0], 2'b00};
        srem_r <= sr_ge ? (sr_sh - sr_trial) : sr_sh;
        root_r <= {root_r[30:0], sr_ge};
      end
      OP_SCX: p1_r <= mul_p;
      OP_SCY: p2_r <= mul_p;
      OP_DIV_INIT_SC: begin
        dd_r[0]  <= p1_r;
        dd_r[1]  <= p2_r;
        rem_r[0] <= '0;
        rem_r[1] <= '0;
        quo_r[0] <= '0;
        quo_r[1] <= '0;
        dvs_r    <= root_r;
      end
      OP_SDONE: begin
        n_r[0] <= sc_v[0];
        n_r[1] <= sc_v[1];
      end
      OP_FRIC: begin
        n_r[0] <= fr_v[0];
        n_r[1] <= fr_v[1];
      end
      OP_EMIT: begin
        omx_r <= m_r[0];
        omy_r <= m_r[1];
        osx_r <= n_r[0];
        osy_r <= n_r[1];
        ocl_r <= clamp_r;
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_move_x  = omx_r;
  assign out_move_y  = omy_r;
  assign out_speed_x = osx_r;
  assign out_speed_y = osy_r;
  assign out_clamped = ocl_r;

`ifndef NO_ASSERTIONS
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |=> out_valid_r)
    else $error("emit did not raise out_valid");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |-> !(out_valid_r && !out_ready))
    else $error("emit overwrote a pending result");
  a_limit_x: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SDONE) |=> (mag32(n_r[0]) <= {1'b0, max_speed_r}))
    else $error("rescaled x exceeds speed limit");
  a_limit_y: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SDONE) |=> (mag32(n_r[1]) <= {1'b0, max_speed_r}))
    else $error("rescaled y exceeds speed limit");
`endif

endmodule
`default_nettype wire

[design/point_mass_step_2d.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_mass_step_2d
// One Euler step of a 2D point mass in Q16.16 with speed limit and friction.
// ----------------------------------------------------------------------------
// Input channel (in_*): a request carries cmd, force, step time and a load
// velocity. cmd 0 integrates one step, cmd 1 loads the velocity.
// Output channel (out_*): one result per request with the position change,
// the new velocity and the clamped flag.
// Config channel (cfg_*): index 0 mass, 1 max_speed, 2 friction; always ready,
// write only while no request is in flight.
// Sequence: a load goes from idle straight to emit and the output register.
// An integrate runs a 64-step restoring divide (force by mass), and when the
// speed limit applies also the 32-step root and a 64-step rescale divide.
// One request is worked at a time; the next is taken as soon as the
// sequencer is back in idle, even while the previous result waits.
// Reset: velocity clears to zero, registers return to defaults, output empty.
// A stalled receiver holds the result; a finished request then waits.
// ----------------------------------------------------------------------------
module point_mass_step_2d (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [31:0]                   in_force_x,
  input  wire logic [31:0]                   in_force_y,
  input  wire logic [15:0]                   in_step_time,
  input  wire logic [31:0]                   in_load_vx,
  input  wire logic [31:0]                   in_load_vy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [31:0]                        out_move_x,
  output logic [31:0]                        out_move_y,
  output logic [31:0]                        out_speed_x,
  output logic [31:0]                        out_speed_y,
  output logic                               out_clamped,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import pms_pkg::*;

  op_t  op;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  pms_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .sts          (sts),
    .in_force_x   (in_force_x),
    .in_force_y   (in_force_y),
    .in_step_time (in_step_time),
    .in_load_vx   (in_load_vx),
    .in_load_vy   (in_load_vy),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_move_x   (out_move_x),
    .out_move_y   (out_move_y),
    .out_speed_x  (out_speed_x),
    .out_speed_y  (out_speed_y),
    .out_clamped  (out_clamped)
  );

endmodule
`default_nettype wire
